### rtl/cau_pkg.sv
package cau_pkg;

    // data format
    localparam int DATA_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int KIND_W     = 4;
    localparam int STATUS_W   = 2;

    // derived widths
    localparam int PROD_W    = 2 * DATA_WIDTH;
    localparam int SUM_W     = PROD_W + 2;
    localparam int QUO_W     = DATA_WIDTH + 1;
    localparam int NUM_STEPS = QUO_W;
    localparam int SQ_REM_W  = DATA_WIDTH + 2;
    localparam int OVF_SH    = DATA_WIDTH + 1 - FRAC_BITS;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_ADD   = 4'd0;
    localparam logic [KIND_W-1:0] KIND_SUB   = 4'd1;
    localparam logic [KIND_W-1:0] KIND_MUL   = 4'd2;
    localparam logic [KIND_W-1:0] KIND_DIV   = 4'd3;
    localparam logic [KIND_W-1:0] KIND_SCALE = 4'd4;
    localparam logic [KIND_W-1:0] KIND_ADDR  = 4'd5;
    localparam logic [KIND_W-1:0] KIND_NEG   = 4'd6;
    localparam logic [KIND_W-1:0] KIND_CONJ  = 4'd7;
    localparam logic [KIND_W-1:0] KIND_MAG   = 4'd8;
    localparam logic [KIND_W-1:0] KIND_SQMAG = 4'd9;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DZ  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAT = 2'd2;

    localparam logic [DATA_WIDTH-1:0] POS_LIM = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic [DATA_WIDTH-1:0] NEG_LIM = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic [DATA_WIDTH-1:0] val;
        logic                  sat;
    } clip_t;

    // one item as it moves through the iteration stages
    typedef struct packed {
        logic [KIND_W-1:0]     kind;
        logic [PROD_W-1:0]     den;
        logic [PROD_W-1:0]     num_re;
        logic [PROD_W-1:0]     num_im;
        logic                  neg_re;
        logic                  neg_im;
        logic                  ovf_re;
        logic                  ovf_im;
        logic [PROD_W-1:0]     rem_re;
        logic [PROD_W-1:0]     rem_im;
        logic [QUO_W-1:0]      q_re;
        logic [QUO_W-1:0]      q_im;
        logic [SQ_REM_W-1:0]   sq_rem;
        logic [DATA_WIDTH-1:0] sq_root;
        logic [DATA_WIDTH-1:0] res_re;
        logic [DATA_WIDTH-1:0] res_im;
        logic                  sat;
        logic                  dz;
    } iter_t;

    // clamp a wide signed value to the signed data range
    function automatic clip_t clip_sum(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi;
        logic signed [SUM_W-1:0] lo;
        clip_t                   c;
        hi = $signed({{(SUM_W-DATA_WIDTH){1'b0}}, POS_LIM});
        lo = $signed({{(SUM_W-DATA_WIDTH){1'b1}}, NEG_LIM});
        if (v > hi) begin
            c.val = POS_LIM;
            c.sat = 1'b1;
        end else if (v < lo) begin
            c.val = NEG_LIM;
            c.sat = 1'b1;
        end else begin
            c.val = v[DATA_WIDTH-1:0];
            c.sat = 1'b0;
        end
        return c;
    endfunction

endpackage

### rtl/cau_front.sv
module cau_front
    import cau_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [KIND_W-1:0]     in_kind,
    input  logic [DATA_WIDTH-1:0] in_a_re,
    input  logic [DATA_WIDTH-1:0] in_a_im,
    input  logic [DATA_WIDTH-1:0] in_b_re,
    input  logic [DATA_WIDTH-1:0] in_b_im,
    output logic                  out_valid,
    output iter_t                 out_it
);

    // stage 1: operand registers
    logic                         v1_reg;
    logic [KIND_W-1:0]            k1_reg;
    logic signed [DATA_WIDTH-1:0] ar1_reg, ai1_reg, br1_reg, bi1_reg;

    // stage 2: products and simple results
    logic                         v2_reg;
    logic [KIND_W-1:0]            k2_reg;
    logic signed [PROD_W-1:0]     p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [PROD_W-1:0]     p0_next, p1_next, p2_next, p3_next, p4_next, p5_next;
    logic [DATA_WIDTH-1:0]        r2_re_reg, r2_im_reg;
    logic                         sat2_reg;
    logic signed [DATA_WIDTH:0]   t_re, t_im;
    logic signed [DATA_WIDTH-1:0] x4, x5;
    logic                         is_mag;
    clip_t                        c2_re, c2_im;

    // stage 3: sums of products
    logic                         v3_reg;
    logic [KIND_W-1:0]            k3_reg;
    logic signed [SUM_W-1:0]      sre3_reg, sim3_reg, sre3_next, sim3_next;
    logic [PROD_W-1:0]            den3_reg;
    logic [DATA_WIDTH-1:0]        r3_re_reg, r3_im_reg;
    logic                         sat3_reg;

    // stage 4: rounding, clamping, magnitudes
    logic                         v4_reg;
    iter_t                        s4_reg, s4_next;
    logic signed [SUM_W-1:0]      sh_re, sh_im;
    logic [PROD_W-1:0]            sq_sh;
    clip_t                        c4_re, c4_im;

    // stage 5: divide overflow check and first remainder
    logic                         v5_reg;
    iter_t                        s5_reg, s5_next;

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // operand capture
    always_ff @(posedge aclk) begin
        if (en) begin
            k1_reg  <= in_kind;
            ar1_reg <= $signed(in_a_re);
            ai1_reg <= $signed(in_a_im);
            br1_reg <= $signed(in_b_re);
            bi1_reg <= $signed(in_b_im);
        end
    end

    // multiplier operands, magnitude ops square the first operand
    assign is_mag = (k1_reg == KIND_MAG) || (k1_reg == KIND_SQMAG);
    assign x4     = is_mag ? ar1_reg : br1_reg;
    assign x5     = is_mag ? ai1_reg : bi1_reg;

    always_comb begin
        p0_next = ar1_reg * br1_reg;
        p1_next = ai1_reg * bi1_reg;
        p2_next = ar1_reg * bi1_reg;
        p3_next = ai1_reg * br1_reg;
        p4_next = x4 * x4;
        p5_next = x5 * x5;
    end

    // add, subtract, negate, conjugate and add real
    always_comb begin
        t_re = '0;
        t_im = '0;
        unique case (k1_reg)
            KIND_ADD: begin
                t_re = $signed({ar1_reg[DATA_WIDTH-1], ar1_reg})
                     + $signed({br1_reg[DATA_WIDTH-1], br1_reg});
                t_im = $signed({ai1_reg[DATA_WIDTH-1], ai1_reg})
                     + $signed({bi1_reg[DATA_WIDTH-1], bi1_reg});
            end
            KIND_SUB: begin
                t_re = $signed({ar1_reg[DATA_WIDTH-1], ar1_reg})
                     - $signed({br1_reg[DATA_WIDTH-1], br1_reg});
                t_im = $signed({ai1_reg[DATA_WIDTH-1], ai1_reg})
                     - $signed({bi1_reg[DATA_WIDTH-1], bi1_reg});
            end
            KIND_ADDR: begin
                t_re = $signed({ar1_reg[DATA_WIDTH-1], ar1_reg})
                     + $signed({br1_reg[DATA_WIDTH-1], br1_reg});
                t_im = $signed({ai1_reg[DATA_WIDTH-1], ai1_reg});
            end
            KIND_NEG: begin
                t_re = -$signed({ar1_reg[DATA_WIDTH-1], ar1_reg});
                t_im = -$signed({ai1_reg[DATA_WIDTH-1], ai1_reg});
            end
            KIND_CONJ: begin
                t_re = $signed({ar1_reg[DATA_WIDTH-1], ar1_reg});
                t_im = -$signed({ai1_reg[DATA_WIDTH-1], ai1_reg});
            end
            default: begin
                t_re = '0;
                t_im = '0;
            end
        endcase
        c2_re = clip_sum(SUM_W'(t_re));
        c2_im = clip_sum(SUM_W'(t_im));
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k2_reg    <= k1_reg;
            p0_reg    <= p0_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
            p3_reg    <= p3_next;
            p4_reg    <= p4_next;
            p5_reg    <= p5_next;
            r2_re_reg <= c2_re.val;
            r2_im_reg <= c2_im.val;
            sat2_reg  <= c2_re.sat | c2_im.sat;
        end
    end

    // combine the products per operation
    always_comb begin
        sre3_next = '0;
        sim3_next = '0;
        unique case (k2_reg)
            KIND_MUL: begin
                sre3_next = SUM_W'(p0_reg) - SUM_W'(p1_reg);
                sim3_next = SUM_W'(p2_reg) + SUM_W'(p3_reg);
            end
            KIND_DIV: begin
                sre3_next = SUM_W'(p0_reg) + SUM_W'(p1_reg);
                sim3_next = SUM_W'(p3_reg) - SUM_W'(p2_reg);
            end
            KIND_SCALE: begin
                sre3_next = SUM_W'(p0_reg);
                sim3_next = SUM_W'(p3_reg);
            end
            default: begin
                sre3_next = '0;
                sim3_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            k3_reg    <= k2_reg;
            sre3_reg  <= sre3_next;
            sim3_reg  <= sim3_next;
            den3_reg  <= $unsigned(p4_reg) + $unsigned(p5_reg);
            r3_re_reg <= r2_re_reg;
            r3_im_reg <= r2_im_reg;
            sat3_reg  <= sat2_reg;
        end
    end

    // floor shift and clamp of products, sign and magnitude for divide
    assign sh_re = sre3_reg >>> FRAC_BITS;
    assign sh_im = sim3_reg >>> FRAC_BITS;
    assign sq_sh = den3_reg >> FRAC_BITS;

    always_comb begin
        c4_re          = clip_sum(sh_re);
        c4_im          = clip_sum(sh_im);
        s4_next        = '0;
        s4_next.kind   = k3_reg;
        s4_next.den    = den3_reg;
        s4_next.res_re = r3_re_reg;
        s4_next.res_im = r3_im_reg;
        s4_next.sat    = sat3_reg;
        unique case (k3_reg)
            KIND_MUL, KIND_SCALE: begin
                s4_next.res_re = c4_re.val;
                s4_next.res_im = c4_im.val;
                s4_next.sat    = c4_re.sat | c4_im.sat;
            end
            KIND_DIV: begin
                s4_next.neg_re = sre3_reg[SUM_W-1];
                s4_next.neg_im = sim3_reg[SUM_W-1];
                s4_next.num_re = sre3_reg[SUM_W-1] ? PROD_W'(-sre3_reg)
                                                   : sre3_reg[PROD_W-1:0];
                s4_next.num_im = sim3_reg[SUM_W-1] ? PROD_W'(-sim3_reg)
                                                   : sim3_reg[PROD_W-1:0];
                s4_next.dz     = (den3_reg == '0);
            end
            KIND_SQMAG: begin
                s4_next.sat    = sq_sh > {{(PROD_W-DATA_WIDTH){1'b0}}, POS_LIM};
                s4_next.res_re = s4_next.sat ? POS_LIM : sq_sh[DATA_WIDTH-1:0];
                s4_next.res_im = '0;
            end
            default: begin
                s4_next.sat = sat3_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_reg <= s4_next;
        end
    end

    // quotient overflow when num >= den * 2^(W+1-F)
    always_comb begin
        s5_next        = s4_reg;
        s5_next.ovf_re = {{OVF_SH{1'b0}}, s4_reg.num_re} >= {s4_reg.den, {OVF_SH{1'b0}}};
        s5_next.ovf_im = {{OVF_SH{1'b0}}, s4_reg.num_im} >= {s4_reg.den, {OVF_SH{1'b0}}};
        s5_next.rem_re = s4_reg.num_re >> OVF_SH;
        s5_next.rem_im = s4_reg.num_im >> OVF_SH;
        s5_next.q_re   = '0;
        s5_next.q_im   = '0;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s5_reg <= s5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_it    = s5_reg;

endmodule

### rtl/cau_step.sv
module cau_step
    import cau_pkg::*;
#(
    parameter int BIT_IDX = 0
)
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  en,
    input  logic  in_valid,
    input  iter_t in_it,
    output logic  out_valid,
    output iter_t out_it
);

    logic                  valid_reg;
    iter_t                 it_reg, it_next;
    logic                  nbit_re, nbit_im;
    logic [PROD_W:0]       rsh_re, rsh_im, dsub_re, dsub_im;
    logic                  ge_re, ge_im;
    logic [SQ_REM_W+1:0]   ssh, trial, ssub;
    logic                  sge;

    // next dividend bit, zero below the fraction point
    if (BIT_IDX >= FRAC_BITS) begin : g_num
        assign nbit_re = in_it.num_re[BIT_IDX-FRAC_BITS];
        assign nbit_im = in_it.num_im[BIT_IDX-FRAC_BITS];
    end else begin : g_frac
        assign nbit_re = 1'b0;
        assign nbit_im = 1'b0;
    end

    // restoring divide step for both parts
    assign rsh_re  = {in_it.rem_re, nbit_re};
    assign rsh_im  = {in_it.rem_im, nbit_im};
    assign ge_re   = rsh_re >= {1'b0, in_it.den};
    assign ge_im   = rsh_im >= {1'b0, in_it.den};
    assign dsub_re = rsh_re - {1'b0, in_it.den};
    assign dsub_im = rsh_im - {1'b0, in_it.den};

    // square root step on one bit pair of the radicand
    if (BIT_IDX < DATA_WIDTH) begin : g_sqrt
        assign ssh   = {in_it.sq_rem, in_it.den[2*BIT_IDX+1 -: 2]};
        assign trial = {2'b00, in_it.sq_root, 2'b01};
        assign sge   = ssh >= trial;
        assign ssub  = ssh - trial;
    end else begin : g_nosqrt
        assign ssh   = '0;
        assign trial = '0;
        assign sge   = 1'b0;
        assign ssub  = '0;
    end

    always_comb begin
        it_next        = in_it;
        it_next.rem_re = ge_re ? dsub_re[PROD_W-1:0] : rsh_re[PROD_W-1:0];
        it_next.rem_im = ge_im ? dsub_im[PROD_W-1:0] : rsh_im[PROD_W-1:0];
        it_next.q_re   = {in_it.q_re[QUO_W-2:0], ge_re};
        it_next.q_im   = {in_it.q_im[QUO_W-2:0], ge_im};
        if (BIT_IDX < DATA_WIDTH) begin
            it_next.sq_rem  = sge ? ssub[SQ_REM_W-1:0] : ssh[SQ_REM_W-1:0];
            it_next.sq_root = {in_it.sq_root[DATA_WIDTH-2:0], sge};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            it_reg <= it_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_it    = it_reg;

endmodule

### rtl/cau_back.sv
module cau_back
    import cau_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  iter_t                   in_it,
    output logic                    m_tvalid,
    output logic [2*DATA_WIDTH-1:0] m_tdata,
    output logic [STATUS_W-1:0]     m_tuser
);

    logic                    valid_reg;
    logic [2*DATA_WIDTH-1:0] data_reg, data_next;
    logic [STATUS_W-1:0]     status_reg, status_next;
    clip_t                   cq_re, cq_im;
    logic [DATA_WIDTH-1:0]   re, im;
    logic                    sat, dz, root_sat;

    // clamp a quotient magnitude with its sign
    function automatic clip_t clip_quo(input logic neg, input logic ovf,
                                       input logic [QUO_W-1:0] q);
        clip_t c;
        if (neg) begin
            c.sat = ovf || (q > {1'b0, NEG_LIM});
            c.val = c.sat ? NEG_LIM : DATA_WIDTH'(-q);
        end else begin
            c.sat = ovf || (q > {1'b0, POS_LIM});
            c.val = c.sat ? POS_LIM : q[DATA_WIDTH-1:0];
        end
        return c;
    endfunction

    assign cq_re    = clip_quo(in_it.neg_re, in_it.ovf_re, in_it.q_re);
    assign cq_im    = clip_quo(in_it.neg_im, in_it.ovf_im, in_it.q_im);
    assign root_sat = in_it.sq_root > POS_LIM;

    // final selection per operation
    always_comb begin
        re  = in_it.res_re;
        im  = in_it.res_im;
        sat = in_it.sat;
        dz  = 1'b0;
        unique case (in_it.kind)
            KIND_DIV: begin
                if (in_it.dz) begin
                    re  = '0;
                    im  = '0;
                    sat = 1'b0;
                    dz  = 1'b1;
                end else begin
                    re  = cq_re.val;
                    im  = cq_im.val;
                    sat = cq_re.sat | cq_im.sat;
                end
            end
            KIND_MAG: begin
                re  = root_sat ? POS_LIM : in_it.sq_root;
                im  = '0;
                sat = root_sat;
            end
            default: begin
                sat = in_it.sat;
            end
        endcase
        data_next = {im, re};
        priority if (dz) begin
            status_next = ST_DZ;
        end else if (sat) begin
            status_next = ST_SAT;
        end else begin
            status_next = ST_OK;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            data_reg   <= data_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = status_reg;

endmodule

### rtl/complex_arithmetic_unit_top.sv
// Fixed-point complex ALU (Q15.16). Each transfer on the s_ side carries an
// operation code and two complex operands; each transfer on the m_ side
// returns one complex result and a status code, in input order. The pipeline
// takes one operation per clock while m_tready does not stall it; a result
// passes through five front stages (operand register, six 32x32 multipliers,
// product sums, rounding/clamping, divide overflow check), 33 iteration stages
// that each resolve one quotient bit of the divider (all but the first also
// resolve one root bit of the square root), and the output register. A stall
// on m_tready freezes the whole pipeline; s_tready is high whenever the output
// register is empty or being drained.
module complex_arithmetic_unit_top
    import cau_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [4*DATA_WIDTH-1:0] s_tdata,   // a_re, a_im, b_re, b_im
    input  logic [KIND_W-1:0]       s_tuser,   // kind
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [2*DATA_WIDTH-1:0] m_tdata,   // res_re, res_im
    output logic [STATUS_W-1:0]     m_tuser    // status
);

    logic                en;
    logic [NUM_STEPS:0]  chain_valid;
    iter_t               chain_it [NUM_STEPS+1];

    // global advance: output free or being taken
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    cau_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .in_kind   (s_tuser),
        .in_a_re   (s_tdata[DATA_WIDTH-1:0]),
        .in_a_im   (s_tdata[2*DATA_WIDTH-1:DATA_WIDTH]),
        .in_b_re   (s_tdata[3*DATA_WIDTH-1:2*DATA_WIDTH]),
        .in_b_im   (s_tdata[4*DATA_WIDTH-1:3*DATA_WIDTH]),
        .out_valid (chain_valid[0]),
        .out_it    (chain_it[0])
    );

    // iteration stages, most significant bit first
    for (genvar g = 0; g < NUM_STEPS; g++) begin : g_step
        cau_step #(
            .BIT_IDX (NUM_STEPS - 1 - g)
        ) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (chain_valid[g]),
            .in_it     (chain_it[g]),
            .out_valid (chain_valid[g+1]),
            .out_it    (chain_it[g+1])
        );
    end

    cau_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (chain_valid[NUM_STEPS]),
        .in_it    (chain_it[NUM_STEPS]),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

### rtl/cau_checker.sv
module cau_checker
    import cau_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [2*DATA_WIDTH-1:0] m_tdata,
    input logic [STATUS_W-1:0]     m_tuser
);

    // no result right after reset
    a_reset_clear: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // input side open whenever the output is empty
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // divide by zero returns zero
    a_dz_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_DZ |-> m_tdata == '0)
        else $error("divide by zero result not zero");

    // unused status code never shows
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser != 2'd3)
        else $error("bad status code");

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### verif/complex_arithmetic_unit_top_test.sv
`timescale 1ns / 100ps

module complex_arithmetic_unit_top_test;
    import cau_pkg::*;

    localparam int LATENCY   = 38;
    localparam int N_RANDOM  = 750;
    localparam longint POS_W = 64'sd2147483647;
    localparam longint NEG_W = -64'sd2147483648;
    localparam logic [63:0] QUO_CAP = 64'd1 << 40;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [31:0]         a_re, a_im, b_re, b_im;
        bit                  has_exp;
        logic [31:0]         e_re, e_im;
        logic [STATUS_W-1:0] e_st;
    } vec_t;

    typedef struct {
        logic [31:0]         re, im;
        logic [STATUS_W-1:0] st;
    } cres_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_tvalid = 1'b0;
    logic                    s_tready;
    logic [4*DATA_WIDTH-1:0] s_tdata = '0;
    logic [KIND_W-1:0]       s_tuser = '0;
    logic                    m_tvalid;
    logic                    m_tready = 1'b0;
    logic [2*DATA_WIDTH-1:0] m_tdata;
    logic [STATUS_W-1:0]     m_tuser;

    cres_t result_fifo[$];
    int    mismatches = 0;
    bit    hold_req = 1'b0;
    bit    stim_done = 1'b0;

    complex_arithmetic_unit_top u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #4 aclk = ~aclk;

    // clamp sign-magnitude value
    function automatic longint sat_mag(bit neg, logic [63:0] mag, inout bit sat);
        if (!neg) begin
            if (mag > 64'(POS_W)) begin
                sat = 1'b1;
                return POS_W;
            end
            return longint'(mag);
        end
        if (mag > 64'd2147483648) begin
            sat = 1'b1;
            return NEG_W;
        end
        return -longint'(mag);
    endfunction

    function automatic longint sat_val(longint v, inout bit sat);
        if (v < 0) return sat_mag(1'b1, 64'(-v), sat);
        return sat_mag(1'b0, 64'(v), sat);
    endfunction

    // floored product sum
    function automatic longint prod_round(longint p, longint q, inout bit sat);
        bit neg;
        logic [63:0] m;
        logic [64:0] full;
        full = {p[63], p} + {q[63], q};
        neg = full[64];
        m = neg ? 64'(-full) : full[63:0];
        if (!neg) m = m >> FRAC_BITS;
        else m = (m + 64'd65535) >> FRAC_BITS;
        return sat_mag(neg, m, sat);
    endfunction

    // truncated quotient of a product sum, capped
    function automatic longint quo_round(longint p, longint q, logic [63:0] d, inout bit sat);
        bit neg;
        logic [64:0] full;
        logic [63:0] n, qq, r;
        full = {p[63], p} + {q[63], q};
        neg = full[64];
        n = neg ? 64'(-full) : full[63:0];
        qq = n / d;
        r = n % d;
        if (qq > QUO_CAP) qq = QUO_CAP;
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = r << 1;
            qq = qq << 1;
            if (r >= d) begin
                r = r - d;
                qq[0] = 1'b1;
            end
            if (qq > QUO_CAP) qq = QUO_CAP;
        end
        return sat_mag(neg, qq, sat);
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] root, b;
        root = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0) begin
            if (s >= root + b) begin
                s = s - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic cres_t complex_op(vec_t v);
        longint ar, ai, br, bi, re, im;
        bit sat, dz;
        logic [63:0] den, s;
        cres_t r;
        ar = longint'($signed(v.a_re));
        ai = longint'($signed(v.a_im));
        br = longint'($signed(v.b_re));
        bi = longint'($signed(v.b_im));
        re = 0; im = 0; sat = 0; dz = 0;
        case (v.kind)
            KIND_ADD: begin
                re = sat_val(ar + br, sat);
                im = sat_val(ai + bi, sat);
            end
            KIND_SUB: begin
                re = sat_val(ar - br, sat);
                im = sat_val(ai - bi, sat);
            end
            KIND_MUL: begin
                re = prod_round(ar * br, -(ai * bi), sat);
                im = prod_round(ar * bi, ai * br, sat);
            end
            KIND_DIV: begin
                den = 64'(br * br) + 64'(bi * bi);
                if (den == 0) dz = 1'b1;
                else begin
                    re = quo_round(ar * br, ai * bi, den, sat);
                    im = quo_round(ai * br, -(ar * bi), den, sat);
                end
            end
            KIND_SCALE: begin
                re = prod_round(ar * br, 0, sat);
                im = prod_round(ai * br, 0, sat);
            end
            KIND_ADDR: begin
                re = sat_val(ar + br, sat);
                im = ai;
            end
            KIND_NEG: begin
                re = sat_val(-ar, sat);
                im = sat_val(-ai, sat);
            end
            KIND_CONJ: begin
                re = ar;
                im = sat_val(-ai, sat);
            end
            KIND_MAG: begin
                s = 64'(ar * ar) + 64'(ai * ai);
                re = sat_mag(1'b0, int_sqrt(s), sat);
            end
            KIND_SQMAG: begin
                s = 64'(ar * ar) + 64'(ai * ai);
                re = sat_mag(1'b0, s >> FRAC_BITS, sat);
            end
            default: ;
        endcase
        r.re = re[31:0];
        r.im = im[31:0];
        r.st = dz ? ST_DZ : (sat ? ST_SAT : ST_OK);
        return r;
    endfunction

    function automatic vec_t mk(logic [3:0] k, logic [31:0] ar, logic [31:0] ai,
                                logic [31:0] br, logic [31:0] bi);
        vec_t v;
        v.kind = k; v.a_re = ar; v.a_im = ai; v.b_re = br; v.b_im = bi;
        v.has_exp = 0; v.e_re = 0; v.e_im = 0; v.e_st = ST_OK;
        return v;
    endfunction

    function automatic vec_t mk_exp(vec_t v, logic [31:0] er, logic [31:0] ei,
                                    logic [STATUS_W-1:0] es);
        v.has_exp = 1; v.e_re = er; v.e_im = ei; v.e_st = es;
        return v;
    endfunction

    // random operand, biased toward edges and small values
    function automatic logic [31:0] rand_opnd();
        case ($urandom_range(0, 9))
            0: return POS_LIM;
            1: return NEG_LIM;
            2: return 32'($signed($urandom_range(0, 65536 * 8)) - 32'sd262144);
            3: return 32'($urandom_range(0, 3)) - 32'd1;
            default: return $urandom;
        endcase
    endfunction

    // one transfer on the input side
    task automatic send_item(vec_t v);
        cres_t r;
        r = complex_op(v);
        if (v.has_exp && (r.re !== v.e_re || r.im !== v.e_im || r.st !== v.e_st))
            $display("ERROR: table row disagrees with predictor, kind %0d", v.kind);
        if (v.has_exp) begin
            r.re = v.e_re; r.im = v.e_im; r.st = v.e_st;
        end
        s_tdata <= {v.b_im, v.b_re, v.a_im, v.a_re};
        s_tuser <= v.kind;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        result_fifo.push_back(r);
        @(negedge aclk);
    endtask

    task automatic gap();
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge aclk);
    endtask

    // sender
    initial begin
        vec_t dir[$];
        vec_t v;
        int burst;
        bit drained;
        drained = 1'b0;
        dir.push_back(mk_exp(mk(KIND_ADD, 32'h10000, 32'h20000, 32'h30000, 32'hFFFF0000),
                             32'h40000, 32'h10000, ST_OK));
        dir.push_back(mk_exp(mk(KIND_ADD, POS_LIM, NEG_LIM, 1, 32'hFFFFFFFF),
                             POS_LIM, NEG_LIM, ST_SAT));
        dir.push_back(mk_exp(mk(KIND_SUB, NEG_LIM, POS_LIM, 1, 32'hFFFFFFFF),
                             NEG_LIM, POS_LIM, ST_SAT));
        dir.push_back(mk(KIND_SUB, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0));
        dir.push_back(mk_exp(mk(KIND_MUL, 32'h10000, 32'h10000, 32'h10000, 32'h10000),
                             0, 32'h20000, ST_OK));
        dir.push_back(mk(KIND_MUL, NEG_LIM, NEG_LIM, NEG_LIM, NEG_LIM));
        dir.push_back(mk(KIND_MUL, 32'hFFFFFFFF, 32'h1, 32'h1, 32'hFFFFFFFF));
        dir.push_back(mk_exp(mk(KIND_DIV, 32'h10000, 32'h20000, 0, 0), 0, 0, ST_DZ));
        dir.push_back(mk_exp(mk(KIND_DIV, POS_LIM, NEG_LIM, 0, 0), 0, 0, ST_DZ));
        dir.push_back(mk(KIND_DIV, 32'h10000, 0, 32'h20000, 0));
        dir.push_back(mk(KIND_DIV, POS_LIM, POS_LIM, 1, 0));
        dir.push_back(mk(KIND_DIV, NEG_LIM, 32'h3, NEG_LIM, NEG_LIM));
        dir.push_back(mk(KIND_SCALE, 32'hFFFFFFFF, POS_LIM, 32'h8000, 0));
        dir.push_back(mk(KIND_SCALE, NEG_LIM, 32'h10000, NEG_LIM, 0));
        dir.push_back(mk_exp(mk(KIND_ADDR, 32'h10000, 32'h5555, 32'h10000, 32'h7777),
                             32'h20000, 32'h5555, ST_OK));
        dir.push_back(mk_exp(mk(KIND_ADDR, POS_LIM, 7, POS_LIM, 0), POS_LIM, 7, ST_SAT));
        dir.push_back(mk_exp(mk(KIND_NEG, NEG_LIM, 32'h10000, 0, 0),
                             POS_LIM, 32'hFFFF0000, ST_SAT));
        dir.push_back(mk_exp(mk(KIND_CONJ, 32'h1234, NEG_LIM, 0, 0), 32'h1234, POS_LIM, ST_SAT));
        dir.push_back(mk(KIND_CONJ, POS_LIM, POS_LIM, 0, 0));
        dir.push_back(mk_exp(mk(KIND_MAG, 0, 0, 0, 0), 0, 0, ST_OK));
        dir.push_back(mk(KIND_MAG, NEG_LIM, NEG_LIM, 0, 0));
        dir.push_back(mk(KIND_MAG, 32'h30000, 32'h40000, 0, 0));
        dir.push_back(mk(KIND_SQMAG, NEG_LIM, NEG_LIM, 0, 0));
        dir.push_back(mk(KIND_SQMAG, 32'h20000, 32'hFFFF0000, 0, 0));
        dir.push_back(mk_exp(mk(4'd15, POS_LIM, POS_LIM, POS_LIM, POS_LIM), 0, 0, ST_OK));

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir[i]) send_item(dir[i]);
        s_tvalid <= 1'b0;

        for (int n = 0; n < N_RANDOM; ) begin
            // long receiver hold while input keeps coming
            if (n >= 200 && !hold_req) hold_req = 1'b1;
            // drain fully once
            if (n >= 450 && !drained) begin
                s_tvalid <= 1'b0;
                wait (result_fifo.size() == 0);
                @(negedge aclk);
                drained = 1'b1;
            end
            burst = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
            for (int j = 0; j < burst && n < N_RANDOM; j++, n++) begin
                v.kind = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(10, 15))
                                                     : 4'($urandom_range(0, 9));
                v.a_re = rand_opnd(); v.a_im = rand_opnd();
                v.b_re = rand_opnd(); v.b_im = rand_opnd();
                if (v.kind == KIND_DIV && $urandom_range(0, 7) == 0) begin
                    v.b_re = 0; v.b_im = 0;
                end
                v.has_exp = 0;
                send_item(v);
            end
            gap();
        end
        s_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver with its own stall pattern
    initial begin
        int phase;
        bit hold_done;
        hold_done = 0;
        phase = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (150) @(negedge aclk);
                hold_done = 1;
            end
            phase = (phase + 1) % 64;
            if (phase < 20) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 2) != 0);
        end
    end

    // result checker
    always @(posedge aclk) begin
        cres_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (result_fifo.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: unexpected result transfer");
            end else begin
                e = result_fifo.pop_front();
                if (m_tdata[31:0] !== e.re || m_tdata[63:32] !== e.im || m_tuser !== e.st) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: exp re %h im %h st %0d, got re %h im %h st %0d",
                                 e.re, e.im, e.st, m_tdata[31:0], m_tdata[63:32], m_tuser);
                end
            end
        end
    end

    // end of run
    initial begin
        wait (stim_done);
        wait (result_fifo.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatches == 0 && result_fifo.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
